// ----- design/vgci_pkg.sv -----
// Shared types and constants for the voxel grid cell index core.
package vgci_pkg;

	localparam int COORD_W   = 32;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN     = 3'd0,
		REG_X_MAX     = 3'd1,
		REG_Y_MIN     = 3'd2,
		REG_Y_MAX     = 3'd3,
		REG_RANGE_MIN = 3'd4,
		REG_RANGE_MAX = 3'd5
	} cfg_reg_t;

	// Register values after reset, Q16.16 meters.
	localparam logic signed [COORD_W-1:0] X_MIN_RST     = 32'sd0;
	localparam logic signed [COORD_W-1:0] X_MAX_RST     = 32'sd1310720;
	localparam logic signed [COORD_W-1:0] Y_MIN_RST     = -32'sd1310720;
	localparam logic signed [COORD_W-1:0] Y_MAX_RST     = 32'sd1310720;
	localparam logic signed [COORD_W-1:0] RANGE_MIN_RST = 32'sd6554;
	localparam logic signed [COORD_W-1:0] RANGE_MAX_RST = 32'sd1966080;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] range_value;
	} in_t;

	typedef struct packed {
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [4:0]  cell_range;
		logic [16:0] cell_index;
		logic        limits_bad;
	} out_t;

endpackage

// ----- design/vgci_lane.sv -----
// One axis lane: clamp, offset, scale by the cell count and a pipelined restoring divider.
module vgci_lane #(
	parameter int CELLS = 64,
	parameter int QW    = 7
) (
	input  logic                                  clk,
	input  logic [QW+1:0]                         en,
	input  logic signed [vgci_pkg::COORD_W-1:0]   coord,
	input  logic signed [vgci_pkg::COORD_W-1:0]   lo,
	input  logic signed [vgci_pkg::COORD_W-1:0]   hi,
	output logic [QW-1:0]                         quot,
	output logic                                  bad
);

	localparam int CW = vgci_pkg::COORD_W;
	localparam int PW = CW + QW;

	logic signed [CW-1:0] c_cl;
	logic signed [CW:0]   diff_w;
	logic signed [CW:0]   span_w;
	logic                 bad_w;

	logic [CW-1:0] diff_s1;
	logic [CW-1:0] span_s1;
	logic          bad_s1;

	logic [PW-1:0] prod_s2;
	logic [CW-1:0] span_s2;
	logic          bad_s2;

	// Element i of these arrays is the state after i divider steps.
	logic [CW-1:0] rem_sd  [0:QW];
	logic [QW-1:0] lq_sd   [0:QW];
	logic [CW-1:0] span_sd [0:QW];
	logic          bad_sd  [0:QW];

	always_comb begin
		bad_w = (lo >= hi);
		if (coord < lo) begin
			c_cl = lo;
		end else if (coord > hi) begin
			c_cl = hi;
		end else begin
			c_cl = coord;
		end
		diff_w = {c_cl[CW-1], c_cl} - {lo[CW-1], lo};
		span_w = {hi[CW-1], hi} - {lo[CW-1], lo};
	end

	// A bad axis divides zero by one so its quotient comes out as zero.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			diff_s1 <= bad_w ? '0 : diff_w[CW-1:0];
			span_s1 <= bad_w ? CW'(1) : span_w[CW-1:0];
			bad_s1  <= bad_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2 <= PW'(diff_s1) * PW'(CELLS);
			span_s2 <= span_s1;
			bad_s2  <= bad_s1;
		end
	end

	// The product is below span * 2^QW, so its upper part already sits below span.
	assign rem_sd[0]  = prod_s2[PW-1:QW];
	assign lq_sd[0]   = prod_s2[QW-1:0];
	assign span_sd[0] = span_s2;
	assign bad_sd[0]  = bad_s2;

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [CW:0]   trial;
		logic          ge;
		logic [CW-1:0] rem_nx;

		always_comb begin
			trial  = {rem_sd[i], lq_sd[i][QW-1]};
			ge     = (trial >= {1'b0, span_sd[i]});
			rem_nx = ge ? CW'(trial - {1'b0, span_sd[i]}) : trial[CW-1:0];
		end

		always_ff @(posedge clk) begin
			if (en[2+i]) begin
				rem_sd[i+1]  <= rem_nx;
				lq_sd[i+1]   <= (lq_sd[i] << 1) | QW'(ge);
				span_sd[i+1] <= span_sd[i];
				bad_sd[i+1]  <= bad_sd[i];
			end
		end
	end

	assign quot = lq_sd[QW];
	assign bad  = bad_sd[QW];

endmodule

// ----- design/vgci_merge.sv -----
// Merge stage: caps the lane quotients and forms the linear cell index.
module vgci_merge #(
	parameter int CELLS_X = 64,
	parameter int CELLS_Y = 64,
	parameter int CELLS_D = 32,
	parameter int QW      = 7
) (
	input  logic               clk,
	input  logic [1:0]         en,
	input  logic [QW-1:0]      qx,
	input  logic [QW-1:0]      qy,
	input  logic [QW-1:0]      qd,
	input  logic               bad_x,
	input  logic               bad_y,
	input  logic               bad_d,
	output vgci_pkg::out_t     res
);

	localparam int LW = 17;

	logic [LW-1:0] cx_s1;
	logic [LW-1:0] cy_s1;
	logic [LW-1:0] cd_s1;
	logic          bad_s1;
	logic [LW-1:0] lin_w;
	vgci_pkg::out_t res_s2;

	// A point sitting exactly on the upper limit lands on the last cell.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cx_s1  <= LW'((qx >= QW'(CELLS_X)) ? QW'(CELLS_X - 1) : qx);
			cy_s1  <= LW'((qy >= QW'(CELLS_Y)) ? QW'(CELLS_Y - 1) : qy);
			cd_s1  <= LW'((qd >= QW'(CELLS_D)) ? QW'(CELLS_D - 1) : qd);
			bad_s1 <= bad_x | bad_y | bad_d;
		end
	end

	assign lin_w = cx_s1 * LW'(CELLS_Y * CELLS_D) + cy_s1 * LW'(CELLS_D) + cd_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			res_s2.cell_x     <= cx_s1[5:0];
			res_s2.cell_y     <= cy_s1[5:0];
			res_s2.cell_range <= cd_s1[4:0];
			res_s2.cell_index <= lin_w;
			res_s2.limits_bad <= bad_s1;
		end
	end

	assign res = res_s2;

endmodule

// ----- design/voxel_grid_cell_index_core.sv -----
// Top level of the voxel grid cell index core: registers, lanes, merge and flow control.
// Stage order: clamp, scale, divider, cap, output register. QW = clog2(max cell count + 1)
// (7 with the default 64 x 64 x 32 grid); the divider makes one quotient bit a stage.
// Throughput: one point per cycle; each stage refills as soon as its content moves on,
// so input beats keep flowing while a result waits, until the pipeline is full.
// Reset: arst_n clears all valid flags and loads the default limits; no clearing pass.
module voxel_grid_cell_index_core #(
	parameter int CELLS_X = 64,
	parameter int CELLS_Y = 64,
	parameter int CELLS_D = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  vgci_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output vgci_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vgci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vgci_pkg::COORD_W-1:0]        cfg_data
);

	// Quotient width per axis; all lanes share the widest so they stay in step.
	localparam int QX = $clog2(CELLS_X + 1);
	localparam int QY = $clog2(CELLS_Y + 1);
	localparam int QD = $clog2(CELLS_D + 1);
	localparam int QXY = (QX > QY) ? QX : QY;
	localparam int QW  = (QXY > QD) ? QXY : QD;
	// Stages: clamp, scale, QW divider steps, cap, output register.
	localparam int NS = QW + 4;

	localparam int CW = vgci_pkg::COORD_W;

	logic signed [CW-1:0] x_min_q;
	logic signed [CW-1:0] x_max_q;
	logic signed [CW-1:0] y_min_q;
	logic signed [CW-1:0] y_max_q;
	logic signed [CW-1:0] range_min_q;
	logic signed [CW-1:0] range_max_q;

	// The register file is always ready for a beat; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q     <= vgci_pkg::X_MIN_RST;
			x_max_q     <= vgci_pkg::X_MAX_RST;
			y_min_q     <= vgci_pkg::Y_MIN_RST;
			y_max_q     <= vgci_pkg::Y_MAX_RST;
			range_min_q <= vgci_pkg::RANGE_MIN_RST;
			range_max_q <= vgci_pkg::RANGE_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vgci_pkg::REG_X_MIN:     x_min_q     <= cfg_data;
				vgci_pkg::REG_X_MAX:     x_max_q     <= cfg_data;
				vgci_pkg::REG_Y_MIN:     y_min_q     <= cfg_data;
				vgci_pkg::REG_Y_MAX:     y_max_q     <= cfg_data;
				vgci_pkg::REG_RANGE_MIN: range_min_q <= cfg_data;
				vgci_pkg::REG_RANGE_MAX: range_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Flow control. Stage k may load when it is empty or when its content moves on.
	// The chain runs backward from the consumer, so a bubble anywhere lets new beats in.
	logic [NS:0]   en;
	logic [NS-1:0] vld_q;

	assign en[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NS-1];

	// Three lanes, one per axis, all driven by the same stage enables.
	logic [QW-1:0] qx;
	logic [QW-1:0] qy;
	logic [QW-1:0] qd;
	logic          bad_x;
	logic          bad_y;
	logic          bad_d;

	vgci_lane #(.CELLS(CELLS_X), .QW(QW)) u_lane_x (
		.clk   (clk),
		.en    (en[QW+1:0]),
		.coord (in_data.x_coord),
		.lo    (x_min_q),
		.hi    (x_max_q),
		.quot  (qx),
		.bad   (bad_x)
	);

	vgci_lane #(.CELLS(CELLS_Y), .QW(QW)) u_lane_y (
		.clk   (clk),
		.en    (en[QW+1:0]),
		.coord (in_data.y_coord),
		.lo    (y_min_q),
		.hi    (y_max_q),
		.quot  (qy),
		.bad   (bad_y)
	);

	vgci_lane #(.CELLS(CELLS_D), .QW(QW)) u_lane_d (
		.clk   (clk),
		.en    (en[QW+1:0]),
		.coord (in_data.range_value),
		.lo    (range_min_q),
		.hi    (range_max_q),
		.quot  (qd),
		.bad   (bad_d)
	);

	// The merge stage caps each index and builds the x-major linear index.
	vgci_merge #(
		.CELLS_X (CELLS_X),
		.CELLS_Y (CELLS_Y),
		.CELLS_D (CELLS_D),
		.QW      (QW)
	) u_merge (
		.clk   (clk),
		.en    (en[QW+3:QW+2]),
		.qx    (qx),
		.qy    (qy),
		.qd    (qd),
		.bad_x (bad_x),
		.bad_y (bad_y),
		.bad_d (bad_d),
		.res   (out_data)
	);

endmodule

// ----- tb/tb_voxel_grid_cell_index_core.sv -----
// Self-checking testbench for the voxel grid cell index core, with its own cell quantizer.
`timescale 1ns / 1ps

module tb_voxel_grid_cell_index_core;

	localparam int CELLS_X = 64;
	localparam int CELLS_Y = 64;
	localparam int CELLS_D = 32;

	// Used only to size the final wait for stray results.
	localparam int LATENCY = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTINGS_COUNT = 6;
	localparam int POINTS_PER_SETTING = 112;
	localparam int REPORT_LIMIT = 10;
	localparam int CORNER_COUNT = 14;

	// Register indexes past the last limit register; writes there must be ignored.
	localparam logic [vgci_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [vgci_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Axis numbering inside the quantizer.
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_D = 2;

	// The scoreboard keeps its own copy of the six limit registers and turns every
	// accepted point into the cell it must land in. Results come back in order, so
	// a plain queue of expected cells is enough.
	class cell_index_scoreboard;
		logic signed [vgci_pkg::COORD_W-1:0] lim_lo [3];
		logic signed [vgci_pkg::COORD_W-1:0] lim_hi [3];
		vgci_pkg::out_t cell_q [$];
		int errors;
		int checked;
		int flagged;
		int clamped;

		function new();
			lim_lo[AXIS_X] = vgci_pkg::X_MIN_RST;
			lim_hi[AXIS_X] = vgci_pkg::X_MAX_RST;
			lim_lo[AXIS_Y] = vgci_pkg::Y_MIN_RST;
			lim_hi[AXIS_Y] = vgci_pkg::Y_MAX_RST;
			lim_lo[AXIS_D] = vgci_pkg::RANGE_MIN_RST;
			lim_hi[AXIS_D] = vgci_pkg::RANGE_MAX_RST;
			errors = 0;
			checked = 0;
			flagged = 0;
			clamped = 0;
		endfunction

		// Mirrors a register write; unmapped indexes leave every limit alone.
		function void set_limit(logic [vgci_pkg::CFG_IDX_W-1:0] idx,
			logic [vgci_pkg::COORD_W-1:0] val);
			unique case (vgci_pkg::cfg_reg_t'(idx))
				vgci_pkg::REG_X_MIN:     lim_lo[AXIS_X] = val;
				vgci_pkg::REG_X_MAX:     lim_hi[AXIS_X] = val;
				vgci_pkg::REG_Y_MIN:     lim_lo[AXIS_Y] = val;
				vgci_pkg::REG_Y_MAX:     lim_hi[AXIS_Y] = val;
				vgci_pkg::REG_RANGE_MIN: lim_lo[AXIS_D] = val;
				vgci_pkg::REG_RANGE_MAX: lim_hi[AXIS_D] = val;
				default: ;
			endcase
		endfunction

		// Exact floor of cells * (c - lo) / (hi - lo) after clamping c into [lo, hi].
		// The product stays below 2^45, so 64-bit arithmetic is exact. A point sitting
		// on the upper limit would land one past the last cell and is pulled back.
		// Returns -1 for an axis whose minimum is not below its maximum.
		function longint axis_cell(logic signed [vgci_pkg::COORD_W-1:0] coord, int axis,
			longint cells);
			longint c;
			longint lo;
			longint hi;
			longint q;
			c = longint'(coord);
			lo = longint'(lim_lo[axis]);
			hi = longint'(lim_hi[axis]);
			if (lo >= hi) begin
				return -1;
			end
			if (c < lo || c > hi) begin
				clamped++;
			end
			if (c < lo) begin
				c = lo;
			end
			if (c > hi) begin
				c = hi;
			end
			q = ((c - lo) * cells) / (hi - lo);
			if (q >= cells) begin
				q = cells - 1;
			end
			return q;
		endfunction

		// Called on every accepted input beat.
		function void note_point(vgci_pkg::in_t p);
			longint cx;
			longint cy;
			longint cd;
			longint lin;
			bit bad;
			vgci_pkg::out_t exp_res;
			bad = 0;
			cx = axis_cell($signed(p.x_coord), AXIS_X, CELLS_X);
			cy = axis_cell($signed(p.y_coord), AXIS_Y, CELLS_Y);
			cd = axis_cell($signed(p.range_value), AXIS_D, CELLS_D);
			if (cx < 0) begin
				bad = 1;
				cx = 0;
			end
			if (cy < 0) begin
				bad = 1;
				cy = 0;
			end
			if (cd < 0) begin
				bad = 1;
				cd = 0;
			end
			lin = cx * CELLS_Y * CELLS_D + cy * CELLS_D + cd;
			exp_res.cell_x = cx[5:0];
			exp_res.cell_y = cy[5:0];
			exp_res.cell_range = cd[4:0];
			exp_res.cell_index = lin[16:0];
			exp_res.limits_bad = bad;
			cell_q = {cell_q, exp_res};
		endfunction

		// Called on every accepted output beat; compares it with the oldest expectation.
		function void check_cell(vgci_pkg::out_t got);
			vgci_pkg::out_t want;
			if (cell_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0t: unexpected result x=%0d y=%0d d=%0d idx=%0d bad=%0b",
						$time, got.cell_x, got.cell_y, got.cell_range, got.cell_index,
						got.limits_bad);
				end
				return;
			end
			want = cell_q.pop_front();
			checked++;
			if (want.limits_bad) begin
				flagged++;
			end
			if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
				got.cell_range !== want.cell_range || got.cell_index !== want.cell_index ||
				got.limits_bad !== want.limits_bad) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0t: mismatch, expected x=%0d y=%0d d=%0d idx=%0d bad=%0b",
						$time, want.cell_x, want.cell_y, want.cell_range, want.cell_index,
						want.limits_bad);
					$display("%0t:           got x=%0d y=%0d d=%0d idx=%0d bad=%0b",
						$time, got.cell_x, got.cell_y, got.cell_range, got.cell_index,
						got.limits_bad);
				end
			end
		endfunction

		function int pending();
			return cell_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	vgci_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	vgci_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [vgci_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vgci_pkg::COORD_W-1:0] cfg_data = '0;

	// Percent of cycles in which the point source holds back and the result sink stalls.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;

	cell_index_scoreboard sb;

	voxel_grid_cell_index_core #(
		.CELLS_X(CELLS_X),
		.CELLS_Y(CELLS_Y),
		.CELLS_D(CELLS_D)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Watchdog. A correct run needs only a small fraction of this budget, even with
	// every point meeting both the longest source gaps and the longest sink stalls.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result sink. The values read just after the edge are the ones the core saw
	// at that edge, so a beat is taken exactly when valid and ready were both high.
	// Ready is then redrawn for the next edge according to the current stall rate.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_cell(out_data);
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offers one point and returns at the edge where it is taken. Valid is left
	// high on return so that back-to-back beats never lower and raise it in the
	// same time step; it only drops when a gap is drawn or the stream pauses.
	task automatic send_point(input vgci_pkg::in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sb.note_point(p);
	endtask

	// Stops the point stream and waits until every expected cell has come back.
	// Every point yields exactly one result, so nothing can still be in flight.
	task automatic drain_points();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// One configuration beat. As with points, valid stays high between writes.
	task automatic write_reg(input logic [vgci_pkg::CFG_IDX_W-1:0] idx,
		input logic [vgci_pkg::COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.set_limit(idx, val);
	endtask

	// Loads a full set of limits, followed by writes to the two spare indexes that
	// carry random data and must not disturb anything.
	task automatic load_limits(input logic [vgci_pkg::COORD_W-1:0] v [6]);
		write_reg(vgci_pkg::REG_X_MIN, v[0]);
		write_reg(vgci_pkg::REG_X_MAX, v[1]);
		write_reg(vgci_pkg::REG_Y_MIN, v[2]);
		write_reg(vgci_pkg::REG_Y_MAX, v[3]);
		write_reg(vgci_pkg::REG_RANGE_MIN, v[4]);
		write_reg(vgci_pkg::REG_RANGE_MAX, v[5]);
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		cfg_valid <= 1'b0;
	endtask

	function automatic vgci_pkg::in_t make_point(logic [vgci_pkg::COORD_W-1:0] x,
		logic [vgci_pkg::COORD_W-1:0] y, logic [vgci_pkg::COORD_W-1:0] d);
		vgci_pkg::in_t p;
		p.x_coord = x;
		p.y_coord = y;
		p.range_value = d;
		return p;
	endfunction

	// Draws one coordinate for an axis. Four draws in ten fall inside the limits with
	// random content, as many sit exactly on or just past a limit, and the
	// rest are fully random 32-bit words that exercise every bit and the clamps.
	function automatic logic [vgci_pkg::COORD_W-1:0] pick_coord(
		logic signed [vgci_pkg::COORD_W-1:0] lo, logic signed [vgci_pkg::COORD_W-1:0] hi);
		longint span;
		longint unsigned r;
		span = longint'(hi) - longint'(lo);
		r = {$urandom(), $urandom()};
		unique case ($urandom_range(9))
			0, 1: return $urandom();
			2: return lo;
			3: return hi;
			4: return lo - 1;
			5: return hi + 1;
			default: begin
				if (span <= 0) begin
					return $urandom();
				end
				return vgci_pkg::COORD_W'(longint'(lo) + longint'(r % longint'(span + 1)));
			end
		endcase
	endfunction

	// Sets both idle rates for a stage of the run: first the source idles less
	// than the sink, then the two rates swap, and the last stretch runs flat out.
	task automatic set_idling(input int stage);
		if (stage < 2) begin
			send_idle_pct = 28;
			recv_idle_pct = 45;
		end else if (stage < 4) begin
			send_idle_pct = 45;
			recv_idle_pct = 28;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	initial begin
		logic [vgci_pkg::COORD_W-1:0] limits [SETTINGS_COUNT][6];
		logic [vgci_pkg::COORD_W-1:0] a;
		logic [vgci_pkg::COORD_W-1:0] b;
		vgci_pkg::in_t corner [CORNER_COUNT];
		vgci_pkg::in_t p;

		sb = new();

		// Limit settings visited by the random part. They cover the widest possible
		// span, spans of one and two units, spans smaller than the cell count,
		// equal and reversed limits on one or two axes, a random draw, and the
		// reset values written back explicitly.
		limits[0] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0002};
		limits[1] = '{32'h0000_0005, 32'h0000_0005, 32'h0000_0064, 32'hffff_ff9c,
			32'h8000_0000, 32'h7fff_ffff};
		limits[2] = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'hffff_0000, 32'h0001_0000};
		for (int k = 0; k < 3; k++) begin
			a = $urandom();
			b = $urandom();
			if ($signed(a) > $signed(b)) begin
				limits[3][2*k] = b;
				limits[3][2*k+1] = a;
			end else begin
				limits[3][2*k] = a;
				limits[3][2*k+1] = b;
			end
		end
		limits[4] = '{vgci_pkg::X_MIN_RST, vgci_pkg::X_MAX_RST, vgci_pkg::Y_MIN_RST,
			vgci_pkg::Y_MAX_RST, vgci_pkg::RANGE_MIN_RST, vgci_pkg::RANGE_MAX_RST};
		limits[5] = '{32'hfffb_0000, 32'h0005_0000, 32'h0000_0000, 32'h0000_003f,
			32'h8000_0000, 32'h8000_001f};

		// Reset is held low from time zero, then released on an edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points under the reset limits: zero, each limit exactly (the
		// upper one must fold into the last cell), one unit inside and outside of
		// each limit, the most negative and most positive words, alternating bit
		// patterns and a point on either side of a cell boundary.
		corner[0] = make_point(32'h0, 32'h0, 32'h0);
		corner[1] = make_point(vgci_pkg::X_MAX_RST, vgci_pkg::Y_MAX_RST,
			vgci_pkg::RANGE_MAX_RST);
		corner[2] = make_point(vgci_pkg::X_MIN_RST, vgci_pkg::Y_MIN_RST,
			vgci_pkg::RANGE_MIN_RST);
		corner[3] = make_point(vgci_pkg::X_MAX_RST - 1, vgci_pkg::Y_MAX_RST - 1,
			vgci_pkg::RANGE_MAX_RST - 1);
		corner[4] = make_point(vgci_pkg::X_MIN_RST + 1, vgci_pkg::Y_MIN_RST + 1,
			vgci_pkg::RANGE_MIN_RST + 1);
		corner[5] = make_point(vgci_pkg::X_MIN_RST - 1, vgci_pkg::Y_MIN_RST - 1,
			vgci_pkg::RANGE_MIN_RST - 1);
		corner[6] = make_point(vgci_pkg::X_MAX_RST + 1, vgci_pkg::Y_MAX_RST + 1,
			vgci_pkg::RANGE_MAX_RST + 1);
		corner[7] = make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		corner[8] = make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		corner[9] = make_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		corner[10] = make_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
		corner[11] = make_point(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
		corner[12] = make_point(32'd20480, 32'h0, 32'd61440);
		corner[13] = make_point(32'd20479, 32'hffff_ffff, 32'd61439);

		set_idling(0);
		foreach (corner[i]) begin
			send_point(corner[i]);
		end
		drain_points();

		// Each setting is loaded while the core is empty, then probed with the
		// all-lower and all-upper corners before the random points.
		for (int s = 0; s < SETTINGS_COUNT; s++) begin
			set_idling(s);
			load_limits(limits[s]);
			send_point(make_point(sb.lim_lo[AXIS_X], sb.lim_lo[AXIS_Y], sb.lim_lo[AXIS_D]));
			send_point(make_point(sb.lim_hi[AXIS_X], sb.lim_hi[AXIS_Y], sb.lim_hi[AXIS_D]));
			for (int n = 0; n < POINTS_PER_SETTING; n++) begin
				p.x_coord = pick_coord(sb.lim_lo[AXIS_X], sb.lim_hi[AXIS_X]);
				p.y_coord = pick_coord(sb.lim_lo[AXIS_Y], sb.lim_hi[AXIS_Y]);
				p.range_value = pick_coord(sb.lim_lo[AXIS_D], sb.lim_hi[AXIS_D]);
				send_point(p);
			end
			drain_points();
		end

		// Give a stray extra result time to surface before judging the run.
		repeat (LATENCY + 8) @(posedge clk);
		sb.errors += sb.pending();

		$display("Checked %0d cells over %0d limit settings plus the reset limits.",
			sb.checked, SETTINGS_COUNT);
		$display("%0d cells carried the bad-limit flag; %0d axis values were clamped.",
			sb.flagged, sb.clamped);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", sb.errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
